// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define WSD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define WSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by wsd_parse, wsd_out and the top level.
package wsd_pkg;

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   localparam logic ITEM_HEADER  = 1'b0;
   localparam logic ITEM_PAYLOAD = 1'b1;

   typedef struct packed {
      logic        item_kind;
      logic        final_fragment;
      logic [2:0]  reserved_bits;
      logic [3:0]  frame_opcode;
      logic        is_masked;
      logic [63:0] payload_length;
      logic [7:0]  payload_byte;
      logic        last_of_frame;
   } result_type;

endpackage

// File: hw/rtl/wsd_parse.sv
// Frame header parser and payload unmasker: per-byte state update and result build.
// Depends on wsd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsd_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                buffer_start,
   output logic                res_valid,
   output wsd_pkg::result_type res
);

   localparam logic [2:0] PH_BYTE0   = 3'd0;
   localparam logic [2:0] PH_BYTE1   = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   logic [2:0]  phase_ff, phase_in, phase_eff;
   logic [2:0]  cnt_ff, cnt_in;
   // bits 7..0 first header byte, bit 8 mask flag, bit 9 64-bit length
   logic [9:0]  flags_ff, flags_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] key_ff, key_in;
   logic [63:0] rem_ff, rem_in;
   logic [1:0]  idx_ff, idx_in;
   logic        len_done;
   logic        hdr_done;
   logic        res_hit;
   logic [1:0]  key_sel;
   logic [7:0]  key_byte;

   // key byte 0 sits in bits 31..24
   assign key_sel  = ~idx_ff;
   assign key_byte = flags_ff[8] ? key_ff[{key_sel, 3'b000} +: 8] : 8'd0;

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      flags_in  = flags_ff;
      len_in    = len_ff;
      key_in    = key_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      len_done  = 1'b0;
      hdr_done  = 1'b0;
      res_hit   = 1'b0;
      res       = '0;

      phase_eff = phase_ff;
      if (buffer_start || (phase_ff == PH_PAYLOAD && rem_ff == 64'd0)) begin
         phase_eff = PH_BYTE0;
      end

      case (phase_eff)
         PH_BYTE1: begin
            flags_in = {1'b0, data_byte[7], flags_ff[7:0]};
            cnt_in   = 3'd0;
            if (data_byte[6:0] == wsd_pkg::LEN_CODE_16 ||
                data_byte[6:0] == wsd_pkg::LEN_CODE_64) begin
               flags_in[9] = (data_byte[6:0] == wsd_pkg::LEN_CODE_64);
               len_in      = 64'd0;
               phase_in    = PH_EXTLEN;
            end else begin
               len_in   = {57'd0, data_byte[6:0]};
               len_done = 1'b1;
            end
         end
         PH_EXTLEN: begin
            len_in = {len_ff[55:0], data_byte};
            if (cnt_ff >= (flags_ff[9] ? 3'd7 : 3'd1)) begin
               len_done = 1'b1;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], data_byte};
            if (cnt_ff >= 3'd3) begin
               hdr_done = 1'b1;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         PH_PAYLOAD: begin
            idx_in  = idx_ff + 2'd1;
            rem_in  = rem_ff - 64'd1;
            res_hit = 1'b1;
            res.item_kind     = wsd_pkg::ITEM_PAYLOAD;
            res.payload_byte  = data_byte ^ key_byte;
            res.last_of_frame = (rem_ff == 64'd1);
            if (rem_ff == 64'd1) begin
               phase_in = PH_BYTE0;
            end
         end
         default: begin
            flags_in = {2'b00, data_byte};
            cnt_in   = 3'd0;
            len_in   = 64'd0;
            key_in   = 32'd0;
            rem_in   = 64'd0;
            idx_in   = 2'd0;
            phase_in = PH_BYTE1;
         end
      endcase

      // length complete: go fetch the key, or close the header right away
      if (len_done) begin
         cnt_in = 3'd0;
         key_in = 32'd0;
         if (flags_in[8]) begin
            phase_in = PH_KEY;
         end else begin
            hdr_done = 1'b1;
         end
      end

      if (hdr_done) begin
         rem_in  = len_in;
         idx_in  = 2'd0;
         cnt_in  = 3'd0;
         res_hit = 1'b1;
         res.item_kind     = wsd_pkg::ITEM_HEADER;
         res.payload_byte  = 8'd0;
         res.last_of_frame = (len_in == 64'd0);
         phase_in = (len_in == 64'd0) ? PH_BYTE0 : PH_PAYLOAD;
      end

      res.final_fragment = flags_in[7];
      res.reserved_bits  = flags_in[6:4];
      res.frame_opcode   = flags_in[3:0];
      res.is_masked      = flags_in[8];
      res.payload_length = len_in;
   end

   assign res_valid = accept & res_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BYTE0;
         cnt_ff   <= 3'd0;
         flags_ff <= 10'd0;
         len_ff   <= 64'd0;
         key_ff   <= 32'd0;
         rem_ff   <= 64'd0;
         idx_ff   <= 2'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         flags_ff <= flags_in;
         len_ff   <= len_in;
         key_ff   <= key_in;
         rem_ff   <= rem_in;
         idx_ff   <= idx_in;
      end
   end

   `WSD_ASSERT_NOW(a_rem_within_len, clock, reset, phase_ff == PH_PAYLOAD, rem_ff <= len_ff, "payload count exceeds frame length")
   `WSD_ASSERT_NOW(a_key_index_tracks, clock, reset, phase_ff == PH_PAYLOAD, idx_ff == 2'(len_ff - rem_ff), "key index out of step with payload count")

endmodule

// File: hw/rtl/wsd_out.sv
// Result register with a skid stage, so the parser keeps accepting while a result waits.
// Depends on wsd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsd_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wsd_pkg::result_type push_data,
   output logic                full,
   output logic                rsp_valid,
   output wsd_pkg::result_type rsp_data,
   input  logic                rsp_stall
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   wsd_pkg::result_type main_data_ff, main_data_in;
   wsd_pkg::result_type skid_data_ff, skid_data_in;
   logic                take;

   assign take = main_valid_ff & ~rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // drain the skid stage into the output register
         if (take) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || take) begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;

   `WSD_ASSERT_NOW(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff, "skid holds a transaction while output register is empty")
   `WSD_ASSERT_NOW(a_no_push_when_full, clock, reset, push, !skid_valid_ff, "result pushed while both stages are full")
   `WSD_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && take, main_valid_ff && !skid_valid_ff, "skid transaction not moved to output register")

endmodule

// File: hw/rtl/websocket_frame_deframer_top.sv
// WebSocket frame deframer: one byte per cycle when not stalled, header and payload results out.
// A result is registered in the output register, or in the skid stage when that one is stalled.
// One byte per cycle while req_stall is low; per-byte state update and unmasking are combinational.
// Output register plus skid stage keep req_stall low while one result waits.
// Reset (synchronous, active high) returns the parser to the first header byte, empties output.
// Depends on wsd_pkg, wsd_parse and wsd_out.

module websocket_frame_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_buffer_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_item_kind,
   output logic        rsp_final_fragment,
   output logic [2:0]  rsp_reserved_bits,
   output logic [3:0]  rsp_frame_opcode,
   output logic        rsp_is_masked,
   output logic [63:0] rsp_payload_length,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_of_frame
);

   logic                accept;
   logic                res_valid;
   wsd_pkg::result_type res;
   wsd_pkg::result_type rsp_data;

   assign accept = req_valid & ~req_stall;

   wsd_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .buffer_start (req_buffer_start),
      .res_valid    (res_valid),
      .res          (res)
   );

   wsd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   assign rsp_item_kind      = rsp_data.item_kind;
   assign rsp_final_fragment = rsp_data.final_fragment;
   assign rsp_reserved_bits  = rsp_data.reserved_bits;
   assign rsp_frame_opcode   = rsp_data.frame_opcode;
   assign rsp_is_masked      = rsp_data.is_masked;
   assign rsp_payload_length = rsp_data.payload_length;
   assign rsp_payload_byte   = rsp_data.payload_byte;
   assign rsp_last_of_frame  = rsp_data.last_of_frame;

endmodule

// File: dv/tb_websocket_frame_deframer_top.sv
// Self-checking testbench for websocket_frame_deframer_top: streams WebSocket frames
// byte by byte, predicts header and payload results in place, and compares them.
// Depends on wsd_pkg and the deframer RTL.
module tb_websocket_frame_deframer_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF    = 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 200;

   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   typedef enum logic [2:0] {
      WAIT_BYTE0, WAIT_BYTE1, EXT_LENGTH, MASK_KEY, PAYLOAD
   } parse_state_type;

   typedef enum logic [1:0] {FORM_7BIT, FORM_16BIT, FORM_64BIT} length_form_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY
   } stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_buffer_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_item_kind;
   logic        rsp_final_fragment;
   logic [2:0]  rsp_reserved_bits;
   logic [3:0]  rsp_frame_opcode;
   logic        rsp_is_masked;
   logic [63:0] rsp_payload_length;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last_of_frame;

   websocket_frame_deframer_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_buffer_start   (req_buffer_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_item_kind      (rsp_item_kind),
      .rsp_final_fragment (rsp_final_fragment),
      .rsp_reserved_bits  (rsp_reserved_bits),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_is_masked      (rsp_is_masked),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last_of_frame  (rsp_last_of_frame)
   );

   always #CLK_HALF clock = ~clock;

   // Parser shadow state
   parse_state_type     pstate      = WAIT_BYTE0;
   logic [2:0]          fld_count   = '0;
   logic [7:0]          lead_byte   = '0;
   logic                mask_flag   = 1'b0;
   logic                long_len    = 1'b0;
   logic [63:0]         frm_len     = '0;
   logic [63:0]         remaining   = '0;
   logic [31:0]         key         = '0;
   logic [1:0]          key_idx     = '0;
   wsd_pkg::result_type predicted_items[$];
   wsd_pkg::result_type due;

   // Stimulus and checking bookkeeping
   int             cycle_count    = 0;
   int             mismatch_count = 0;
   int             bytes_sent     = 0;
   int             headers_seen   = 0;
   int             payload_seen   = 0;
   int             frames_cut     = 0;
   int             burst_left     = 0;
   logic           sender_idling  = 1'b1;
   logic           stream_broken  = 1'b0;
   logic           hold_active    = 1'b0;
   stall_mode_type stall_mode     = STALL_NONE;
   event           long_hold;

   function automatic void record_result(logic kind, logic [7:0] data, logic last);
      wsd_pkg::result_type r;
      r.item_kind      = kind;
      r.final_fragment = lead_byte[7];
      r.reserved_bits  = lead_byte[6:4];
      r.frame_opcode   = lead_byte[3:0];
      r.is_masked      = mask_flag;
      r.payload_length = frm_len;
      r.payload_byte   = data;
      r.last_of_frame  = last;
      predicted_items.push_back(r);
   endfunction

   function automatic void close_header();
      remaining = frm_len;
      key_idx   = '0;
      fld_count = '0;
      record_result(wsd_pkg::ITEM_HEADER, 8'h00, frm_len == 64'd0);
      pstate = (frm_len == 64'd0) ? WAIT_BYTE0 : PAYLOAD;
   endfunction

   function automatic void close_length();
      fld_count = '0;
      key       = '0;
      if (mask_flag) pstate = MASK_KEY;
      else close_header();
   endfunction

   function automatic void deframe_byte(logic [7:0] data, logic start);
      parse_state_type st;
      logic [7:0]      key_byte;
      st = pstate;
      if (start) st = WAIT_BYTE0;
      if (st == PAYLOAD && remaining == 64'd0) st = WAIT_BYTE0;
      case (st)
         WAIT_BYTE1: begin
            mask_flag = data[7];
            long_len  = 1'b0;
            fld_count = '0;
            if (data[6:0] == wsd_pkg::LEN_CODE_16 || data[6:0] == wsd_pkg::LEN_CODE_64) begin
               long_len = (data[6:0] == wsd_pkg::LEN_CODE_64);
               frm_len  = '0;
               pstate   = EXT_LENGTH;
            end else begin
               frm_len = {57'd0, data[6:0]};
               close_length();
            end
         end
         EXT_LENGTH: begin
            frm_len = {frm_len[55:0], data};
            if (fld_count >= (long_len ? 3'd7 : 3'd1)) close_length();
            else fld_count = fld_count + 3'd1;
         end
         MASK_KEY: begin
            key = {key[23:0], data};
            if (fld_count >= 3'd3) close_header();
            else fld_count = fld_count + 3'd1;
         end
         PAYLOAD: begin
            key_byte  = mask_flag ? key[8*(3-key_idx) +: 8] : 8'h00;
            key_idx   = key_idx + 2'd1;
            remaining = remaining - 64'd1;
            record_result(wsd_pkg::ITEM_PAYLOAD, data ^ key_byte, remaining == 64'd0);
            if (remaining == 64'd0) pstate = WAIT_BYTE0;
         end
         default: begin
            lead_byte = data;
            mask_flag = 1'b0;
            long_len  = 1'b0;
            fld_count = '0;
            frm_len   = '0;
            key       = '0;
            remaining = '0;
            key_idx   = '0;
            pstate    = WAIT_BYTE1;
         end
      endcase
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Receiver stall: hold off for a long stretch on request, else follow the current mode
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_active) begin
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < 30);
            STALL_PERIODIC: rsp_stall <= ((cycle_count % 13) < 5);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 99) < 75);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   always begin
      @(long_hold);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   // Compare each accepted transaction against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_items.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none actual kind %0d byte %0h",
                     $time, rsp_item_kind, rsp_payload_byte);
         end else begin
            due = predicted_items.pop_front();
            if (due.item_kind == wsd_pkg::ITEM_HEADER) headers_seen++;
            else payload_seen++;
            check_field("item_kind", due.item_kind, rsp_item_kind);
            check_field("final_fragment", due.final_fragment, rsp_final_fragment);
            check_field("reserved_bits", due.reserved_bits, rsp_reserved_bits);
            check_field("frame_opcode", due.frame_opcode, rsp_frame_opcode);
            check_field("is_masked", due.is_masked, rsp_is_masked);
            check_field("payload_length", due.payload_length, rsp_payload_length);
            check_field("payload_byte", due.payload_byte, rsp_payload_byte);
            check_field("last_of_frame", due.last_of_frame, rsp_last_of_frame);
         end
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic start);
      if (sender_idling && burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = $urandom_range(1, 32);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= data;
      req_buffer_start <= start;
      do @(posedge clock); while (req_stall);
      deframe_byte(data, start);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_items.size() != 0);
   endtask

   // Send one frame; a non-negative cut_at abandons it after that many bytes
   task automatic send_frame(input logic [7:0] lead, input logic masked,
                             input length_form_type form, input logic [63:0] len,
                             input int cut_at, input logic start);
      logic [7:0]  hdr[$];
      logic [63:0] n_pay;
      int          n_ext;
      hdr.push_back(lead);
      case (form)
         FORM_7BIT:  begin hdr.push_back({masked, len[6:0]}); n_ext = 0; end
         FORM_16BIT: begin hdr.push_back({masked, wsd_pkg::LEN_CODE_16}); n_ext = 2; end
         default:    begin hdr.push_back({masked, wsd_pkg::LEN_CODE_64}); n_ext = 8; end
      endcase
      for (int i = n_ext - 1; i >= 0; i--) hdr.push_back(len[8*i +: 8]);
      if (masked) repeat (4) hdr.push_back(8'($urandom));
      n_pay         = len;
      stream_broken = 1'b0;
      if (cut_at >= 0 && cut_at < hdr.size()) begin
         while (hdr.size() > cut_at) hdr.delete(hdr.size() - 1);
         n_pay         = '0;
         stream_broken = 1'b1;
      end else if (cut_at >= 0 && 64'(cut_at - hdr.size()) < len) begin
         n_pay         = 64'(cut_at - hdr.size());
         stream_broken = 1'b1;
      end
      foreach (hdr[i]) send_byte(hdr[i], start && i == 0);
      repeat (n_pay) send_byte(8'($urandom), 1'b0);
      if (stream_broken) frames_cut++;
   endtask

   task automatic send_random_frame();
      logic            masked;
      length_form_type form;
      logic [63:0]     len;
      int              cut_at;
      int              pick;
      masked = 1'($urandom);
      pick   = $urandom_range(0, 99);
      cut_at = -1;
      if (pick < 60) begin
         form = FORM_7BIT;  len = $urandom_range(0, 12);
      end else if (pick < 68) begin
         form = FORM_7BIT;  len = $urandom_range(13, 125);
      end else if (pick < 80) begin
         form = FORM_16BIT; len = $urandom_range(0, 20);
      end else if (pick < 85) begin
         form = FORM_16BIT; len = $urandom_range(0, 65535); cut_at = $urandom_range(1, 24);
      end else if (pick < 95) begin
         form = FORM_64BIT; len = $urandom_range(0, 20);
      end else begin
         form = FORM_64BIT; len = {$urandom, $urandom}; cut_at = $urandom_range(1, 24);
      end
      if (cut_at < 0 && $urandom_range(0, 9) == 0) cut_at = $urandom_range(1, 16);
      send_frame(8'($urandom), masked, form, len, cut_at,
                 stream_broken || $urandom_range(0, 7) == 0);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom));
      stream_broken = 1'b1;
   endtask

   task automatic test_basic_frames();
      stall_mode    = STALL_RANDOM;
      sender_idling = 1'b1;
      // key wraps around after four payload bytes
      send_frame({1'b0, 3'b010, OP_BINARY}, 1'b1, FORM_7BIT, 64'd5, -1, 1'b0);
      // empty frame through a non-minimal 16-bit length
      send_frame({1'b1, 3'b111, OP_CLOSE}, 1'b0, FORM_16BIT, 64'd0, -1, 1'b0);
      wait_drained();
   endtask

   task automatic test_restarts();
      // top length bit set; abandon after one unmasked payload byte
      send_frame({1'b0, 3'b100, OP_CONT}, 1'b0, FORM_64BIT, 64'h8000_0000_0000_0002, 11, 1'b0);
      // restart mid-payload, then abandon inside the extended length
      send_frame({1'b1, 3'b001, OP_PONG}, 1'b1, FORM_16BIT, 64'h0102, 3, 1'b1);
      // restart mid-header into an empty frame
      send_frame({1'b1, 3'b000, OP_PING}, 1'b0, FORM_7BIT, 64'd0, -1, 1'b1);
      wait_drained();
   endtask

   task automatic test_backpressure();
      sender_idling = 1'b0;
      stall_mode    = STALL_NONE;
      -> long_hold;
      send_frame({1'b1, 3'b000, OP_TEXT}, 1'b1, FORM_7BIT, 64'd48, -1, 1'b1);
      // hold the sender until every result is back
      wait_drained();
      sender_idling = 1'b1;
   endtask

   task automatic test_random_stream();
      stall_mode_type modes[4] = '{STALL_RANDOM, STALL_NONE, STALL_PERIODIC, STALL_HEAVY};
      int             target;
      for (int round = 0; round < 4; round++) begin
         stall_mode    = modes[round];
         sender_idling = (round != 1);
         target        = bytes_sent + 425;
         while (bytes_sent < target) begin
            if ($urandom_range(0, 19) == 0) send_noise();
            else send_random_frame();
         end
         wait_drained();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_frames();
      test_restarts();
      test_backpressure();
      test_random_stream();
      wait_drained();
      repeat (4) @(posedge clock);
      $display("Sent %0d bytes; checked %0d headers and %0d payload bytes, %0d frames cut.",
               bytes_sent, headers_seen, payload_seen, frames_cut);
      $display("Receiver ran free, random, periodic and heavy stalls plus one long hold-off.");
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
